// ===== rtl/length_prefixed_message_ring_defines.svh =====
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_defines
// Assertion macros for the message ring. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH
`define LENGTH_PREFIXED_MESSAGE_RING_DEFINES_SVH

`ifndef ASSERT_OFF
`define LPMR_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpmr assertion failed");
`define LPMR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpmr assertion failed");
`else
`define LPMR_ASSERT(lbl, ante, cons)
`define LPMR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/lpmr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types and constants of the length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

  localparam int CMD_W    = 2;
  localparam int LEN_W    = 7;
  localparam int DATA_W   = 8;
  localparam int STATUS_W = 3;

  localparam int BUFFER_BYTES_DEF      = 1024;
  localparam int HEADER_BYTES_DEF      = 8;
  localparam int MAX_MESSAGE_BYTES_DEF = 64;

  typedef enum logic [CMD_W-1:0] {
    CMD_BEGIN = 2'd0,
    CMD_DATA  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_RSVD  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_FULL  = 3'd1,
    ST_EMPTY = 3'd2,
    ST_SMALL = 3'd3,
    ST_SEQ   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_HDR  = 4'b0010,
    S_LEN  = 4'b0100,
    S_DATA = 4'b1000
  } state_t;

  typedef struct packed {
    cmd_t              command;
    logic [LEN_W-1:0]  message_length;
    logic [DATA_W-1:0] data_byte;
    logic [LEN_W-1:0]  capacity;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] data_byte_res;
    logic [LEN_W-1:0]  message_length_res;
    logic              last;
  } out_item_t;

endpackage

// ===== rtl/lpmr_mem.sv =====
// ----------------------------------------------------------------------------
// lpmr_mem
// Byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpmr_mem #(
  parameter int  DEPTH = lpmr_pkg::BUFFER_BYTES_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lpmr_pkg::DATA_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  output logic [lpmr_pkg::DATA_W-1:0] rd_data
);
  import lpmr_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/length_prefixed_message_ring.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_message_ring
// Ring store of length-prefixed byte messages held in one synchronous RAM.
// Begin: header written one byte a cycle in S_HDR; result registered after the last header byte.
// Data byte and refused or out-of-order commands: result in the next cycle.
// Read: length byte fetch, then one payload byte per cycle from S_DATA; the
// registered read of the single RAM port pair puts S_LEN between accept and data.
// Synchronous reset clears the ring pointers (rp, cwp, fill) and control; store contents are not cleared.
// ----------------------------------------------------------------------------
`include "length_prefixed_message_ring_defines.svh"

module length_prefixed_message_ring #(
  parameter int BUFFER_BYTES      = lpmr_pkg::BUFFER_BYTES_DEF,
  parameter int HEADER_BYTES      = lpmr_pkg::HEADER_BYTES_DEF,
  parameter int MAX_MESSAGE_BYTES = lpmr_pkg::MAX_MESSAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lpmr_pkg::in_item_t  in_item,
  output logic                out_valid,
  output lpmr_pkg::out_item_t out_item
);
  import lpmr_pkg::*;

  localparam int PTR_W = $clog2(BUFFER_BYTES);
  localparam int HC_W  = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int CW    = PTR_W + 2;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(BUFFER_BYTES - 1)) begin
      return '0;
    end else begin
      return p + 1'b1;
    end
  endfunction

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [PTR_W-1:0]   cwp_r, cwp_nxt;
  logic [PTR_W-1:0]   fill_r, fill_nxt;
  logic [PTR_W-1:0]   ptr_r, ptr_nxt;
  logic [LEN_W-1:0]   expected_r, expected_nxt;
  logic               open_r, open_nxt;
  logic [HC_W-1:0]    hcnt_r, hcnt_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic [LEN_W-1:0]   cap_r, cap_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [DATA_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [PTR_W-1:0]   mem_raddr;
  logic [DATA_W-1:0]  mem_rdata;

  logic               accept;
  logic [PTR_W:0]     used;
  logic [CW-1:0]      need;
  logic               refuse;
  logic [PTR_W:0]     hdr_sum;
  logic [PTR_W-1:0]   hdr_end;
  logic               too_small;
  logic               data_last;

  lpmr_mem #(
    .DEPTH(BUFFER_BYTES)
  ) u_mem (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    if (cwp_r >= rp_r) begin
      used = {1'b0, cwp_r} - {1'b0, rp_r};
    end else begin
      used = {1'b0, cwp_r} + (PTR_W+1)'(BUFFER_BYTES) - {1'b0, rp_r};
    end
    need   = {1'b0, used} + CW'(1) + CW'(in_item.message_length) + CW'(HEADER_BYTES);
    refuse = (in_item.message_length > LEN_W'(MAX_MESSAGE_BYTES)) ||
             (need > CW'(BUFFER_BYTES));
    hdr_sum = {1'b0, rp_r} + (PTR_W+1)'(HEADER_BYTES);
    if (hdr_sum >= (PTR_W+1)'(BUFFER_BYTES)) begin
      hdr_end = PTR_W'(hdr_sum - (PTR_W+1)'(BUFFER_BYTES));
    end else begin
      hdr_end = hdr_sum[PTR_W-1:0];
    end
    too_small = (mem_rdata > {1'b0, cap_r}) ||
                (mem_rdata > DATA_W'(MAX_MESSAGE_BYTES));
    data_last = ((cnt_r + 1'b1) == len_r);
  end

  always_comb begin
    state_nxt     = state_r;
    rp_nxt        = rp_r;
    cwp_nxt       = cwp_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    expected_nxt  = expected_r;
    open_nxt      = open_r;
    hcnt_nxt      = hcnt_r;
    len_nxt       = len_r;
    cap_nxt       = cap_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    mem_we        = 1'b0;
    mem_waddr     = ptr_r;
    mem_wdata     = '0;
    mem_re        = 1'b0;
    mem_raddr     = rp_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_item_nxt.data_byte_res      = '0;
          out_item_nxt.message_length_res = '0;
          out_item_nxt.last               = 1'b1;
          unique case (in_item.command)
            CMD_BEGIN: begin
              if (open_r) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_SEQ;
              end else if (refuse) begin
                out_valid_nxt                   = 1'b1;
                out_item_nxt.status             = ST_FULL;
                out_item_nxt.message_length_res = in_item.message_length;
              end else begin
                ptr_nxt   = cwp_r;
                hcnt_nxt  = '0;
                len_nxt   = in_item.message_length;
                state_nxt = S_HDR;
              end
            end
            CMD_DATA: begin
              out_valid_nxt = 1'b1;
              if (open_r) begin
                out_item_nxt.status = ST_OK;
                mem_we              = 1'b1;
                mem_waddr           = fill_r;
                mem_wdata           = in_item.data_byte;
                fill_nxt            = ptr_inc(fill_r);
                expected_nxt        = expected_r - 1'b1;
                if (expected_r == LEN_W'(1)) begin
                  cwp_nxt  = ptr_inc(fill_r);
                  open_nxt = 1'b0;
                end
              end else begin
                out_item_nxt.status = ST_SEQ;
              end
            end
            CMD_READ: begin
              if (cwp_r == rp_r) begin
                out_valid_nxt       = 1'b1;
                out_item_nxt.status = ST_EMPTY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = rp_r;
                cap_nxt   = in_item.capacity;
                state_nxt = S_LEN;
              end
            end
            CMD_RSVD: begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_SEQ;
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_SEQ;
            end
          endcase
        end
      end

      S_HDR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r;
        mem_wdata = (hcnt_r == '0) ? DATA_W'(len_r) : '0;
        if (hcnt_r == HC_W'(HEADER_BYTES - 1)) begin
          fill_nxt     = ptr_inc(ptr_r);
          expected_nxt = len_r;
          if (len_r == '0) begin
            cwp_nxt = ptr_inc(ptr_r);
          end else begin
            open_nxt = 1'b1;
          end
          out_valid_nxt                   = 1'b1;
          out_item_nxt.status             = ST_OK;
          out_item_nxt.data_byte_res      = '0;
          out_item_nxt.message_length_res = len_r;
          out_item_nxt.last               = 1'b1;
          state_nxt                       = S_IDLE;
        end else begin
          ptr_nxt  = ptr_inc(ptr_r);
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end

      S_LEN: begin
        out_item_nxt.data_byte_res = '0;
        out_item_nxt.last          = 1'b1;
        if (too_small) begin
          out_valid_nxt                   = 1'b1;
          out_item_nxt.status             = ST_SMALL;
          out_item_nxt.message_length_res = mem_rdata[LEN_W-1:0];
          state_nxt                       = S_IDLE;
        end else if (mem_rdata == '0) begin
          rp_nxt                          = hdr_end;
          out_valid_nxt                   = 1'b1;
          out_item_nxt.status             = ST_OK;
          out_item_nxt.message_length_res = '0;
          state_nxt                       = S_IDLE;
        end else begin
          len_nxt   = mem_rdata[LEN_W-1:0];
          mem_re    = 1'b1;
          mem_raddr = hdr_end;
          ptr_nxt   = hdr_end;
          cnt_nxt   = '0;
          state_nxt = S_DATA;
        end
      end

      S_DATA: begin
        out_valid_nxt                   = 1'b1;
        out_item_nxt.status             = ST_OK;
        out_item_nxt.data_byte_res      = mem_rdata;
        out_item_nxt.message_length_res = len_r;
        out_item_nxt.last               = data_last;
        if (data_last) begin
          rp_nxt    = ptr_inc(ptr_r);
          state_nxt = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_inc(ptr_r);
          ptr_nxt   = ptr_inc(ptr_r);
          cnt_nxt   = cnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rp_r        <= '0;
      cwp_r       <= '0;
      fill_r      <= '0;
      expected_r  <= '0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rp_r        <= rp_nxt;
      cwp_r       <= cwp_nxt;
      fill_r      <= fill_nxt;
      expected_r  <= expected_nxt;
      open_r      <= open_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r      <= ptr_nxt;
    hcnt_r     <= hcnt_nxt;
    len_r      <= len_nxt;
    cap_r      <= cap_nxt;
    cnt_r      <= cnt_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `LPMR_ASSERT_NEXT(a_accept_answered, accept, out_valid || busy)
  `LPMR_ASSERT(a_last_frees, out_valid && out_item.last, !busy)
  `LPMR_ASSERT_NEXT(a_stream_gapless, out_valid && !out_item.last, out_valid)
  `LPMR_ASSERT(a_closed_no_pending, !open_r, expected_r == '0)

endmodule
